>>> rtl/core/i2cmts_pkg.sv
// Shared types and codes for the I2C main transfer sequencer.
package i2cmts_pkg;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_TX    = 2'd1,
    ST_RX    = 2'd2
  } xfer_state_t;

  localparam logic [3:0] KIND_SEND_REQ  = 4'd0;
  localparam logic [3:0] KIND_RECV_REQ  = 4'd1;
  localparam logic [3:0] KIND_START     = 4'd2;
  localparam logic [3:0] KIND_ADDR_DONE = 4'd3;
  localparam logic [3:0] KIND_TX_EMPTY  = 4'd4;
  localparam logic [3:0] KIND_RX_FULL   = 4'd5;
  localparam logic [3:0] KIND_BYTE_DONE = 4'd6;
  localparam logic [3:0] KIND_STOP      = 4'd7;
  localparam logic [3:0] KIND_ERROR     = 4'd8;

  localparam logic [1:0] ACK_NONE    = 2'd0;
  localparam logic [1:0] ACK_DISABLE = 2'd1;
  localparam logic [1:0] ACK_ENABLE  = 2'd2;

  localparam logic [3:0] NT_NONE     = 4'd0;
  localparam logic [3:0] NT_TX_DONE  = 4'd1;
  localparam logic [3:0] NT_RX_DONE  = 4'd2;
  localparam logic [3:0] NT_STOP     = 4'd3;
  localparam logic [3:0] NT_DATA_REQ = 4'd4;
  localparam logic [3:0] NT_DATA_RCV = 4'd5;
  localparam logic [3:0] NT_ERR_BASE = 4'd6;

  localparam logic [2:0] ERR_CODE_MAX = 3'd4;

  localparam int unsigned IN_BITS  = 38;
  localparam int unsigned OUT_BITS = 28;

  // first field in the lowest bits, so it is the last member
  typedef struct packed {
    logic [2:0] error_code;
    logic       tx_empty_flag;
    logic       transmitter;
    logic       main_mode;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
    logic       repeated_start;
    logic [6:0] target_addr;
    logic [7:0] length;
  } event_item_t;

  typedef struct packed {
    logic [3:0]  notify;
    logic [1:0]  ack_action;
    logic        gen_stop;
    logic        gen_start;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic [7:0]  write_byte;
    logic        write_valid;
    xfer_state_t prior_state;
  } step_result_t;

  typedef struct packed {
    xfer_state_t xfer_state;
    logic        events_on;
    logic        errors_on;
    logic [7:0]  bytes_left;
    logic [7:0]  rx_total;
    logic [6:0]  peer_addr;
    logic        keep_bus;
  } xfer_regs_t;

endpackage

>>> rtl/core/i2cmts_step.sv
// Event decode: next transfer state and result for one event.
module i2cmts_step (
  input  i2cmts_pkg::xfer_regs_t   cur,
  input  logic [3:0]               kind,
  input  i2cmts_pkg::event_item_t  item,
  input  logic                     ack_restore_enable,
  input  logic                     subnode_events_enable,
  output i2cmts_pkg::xfer_regs_t   nxt,
  output i2cmts_pkg::step_result_t res
);
  import i2cmts_pkg::*;

  logic       ev;
  logic       er;
  logic [7:0] bl;

  assign ev = cur.events_on | subnode_events_enable;
  assign er = cur.errors_on | subnode_events_enable;

  always_comb begin
    nxt             = cur;
    bl              = cur.bytes_left;
    res             = '0;
    res.prior_state = cur.xfer_state;
    res.ack_action  = ACK_NONE;
    res.notify      = NT_NONE;
    case (kind)
      KIND_SEND_REQ, KIND_RECV_REQ: begin
        if (cur.xfer_state == ST_READY) begin
          nxt.bytes_left = item.length;
          if (kind == KIND_RECV_REQ) begin
            nxt.rx_total   = item.length;
            nxt.xfer_state = ST_RX;
          end else begin
            nxt.xfer_state = ST_TX;
          end
          nxt.peer_addr = item.target_addr;
          nxt.keep_bus  = item.repeated_start;
          nxt.events_on = 1'b1;
          nxt.errors_on = 1'b1;
          res.gen_start = 1'b1;
        end
      end
      KIND_START: begin
        if (ev && cur.xfer_state == ST_TX) begin
          res.write_valid = 1'b1;
          res.write_byte  = {cur.peer_addr, 1'b0};
        end else if (ev && cur.xfer_state == ST_RX) begin
          res.write_valid = 1'b1;
          res.write_byte  = {cur.peer_addr, 1'b1};
        end
      end
      KIND_ADDR_DONE: begin
        // single-byte receive must NACK its only byte
        if (ev && item.main_mode && cur.xfer_state == ST_RX && cur.rx_total == 8'd1) begin
          res.ack_action = ACK_DISABLE;
        end
      end
      KIND_TX_EMPTY: begin
        if (ev) begin
          if (item.main_mode) begin
            if (cur.xfer_state == ST_TX && cur.bytes_left != 8'd0) begin
              res.write_valid = 1'b1;
              res.write_byte  = item.tx_byte;
              nxt.bytes_left  = cur.bytes_left - 8'd1;
            end
          end else if (item.transmitter) begin
            res.notify = NT_DATA_REQ;
          end
        end
      end
      KIND_RX_FULL: begin
        if (ev) begin
          if (item.main_mode) begin
            if (cur.xfer_state == ST_RX) begin
              if (cur.rx_total != 8'd0) begin
                if (cur.rx_total > 8'd1 && cur.bytes_left == 8'd2) begin
                  res.ack_action = ACK_DISABLE;
                end
                res.read_valid = 1'b1;
                res.read_byte  = item.rx_byte;
                if (cur.bytes_left != 8'd0) begin
                  bl = cur.bytes_left - 8'd1;
                end
              end
              nxt.bytes_left = bl;
              if (bl == 8'd0) begin
                res.gen_stop   = ~cur.keep_bus;
                nxt.xfer_state = ST_READY;
                nxt.events_on  = 1'b0;
                nxt.rx_total   = 8'd0;
                if (ack_restore_enable) begin
                  res.ack_action = ACK_ENABLE;
                end
                res.notify = NT_RX_DONE;
              end
            end
          end else if (!item.transmitter) begin
            res.notify = NT_DATA_RCV;
          end
        end
      end
      KIND_BYTE_DONE: begin
        if (ev && cur.xfer_state == ST_TX && item.tx_empty_flag && cur.bytes_left == 8'd0) begin
          res.gen_stop   = ~cur.keep_bus;
          nxt.xfer_state = ST_READY;
          nxt.events_on  = 1'b0;
          res.notify     = NT_TX_DONE;
        end
      end
      KIND_STOP: begin
        if (ev) begin
          res.notify = NT_STOP;
        end
      end
      KIND_ERROR: begin
        if (er && item.error_code <= ERR_CODE_MAX) begin
          res.notify = NT_ERR_BASE + {1'b0, item.error_code};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/i2c_master_transfer_sequencer_top.sv
// I2C main transfer sequencer: event stream in, bus action stream out.
// The result of each accepted event is registered into the output register.
// Throughput: one event per cycle; the output register frees s_tready whenever
// it is empty or being drained in the same cycle.
// Reset (rst, synchronous): state ready, counters and enables cleared,
// ack_restore_enable set, subnode_events_enable cleared, output empty.
module i2c_master_transfer_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // length[7:0], target_addr[14:8], repeated_start[15], tx_byte[23:16],
  // rx_byte[31:24], main_mode[32], transmitter[33], tx_empty_flag[34],
  // error_code[37:35], zero fill
  input  logic [39:0] s_tdata,
  // kind[3:0]
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // prior_state[1:0], write_valid[2], write_byte[10:3], read_valid[11],
  // read_byte[19:12], gen_start[20], gen_stop[21], ack_action[23:22],
  // notify[27:24], zero fill
  output logic [31:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);
  import i2cmts_pkg::*;

  localparam logic CFG_ACK_RESTORE = 1'b0;
  localparam logic CFG_SUBNODE_EV  = 1'b1;

  logic         ack_restore_enable;
  logic         subnode_events_enable;
  xfer_regs_t   regs;
  xfer_regs_t   regs_next;
  step_result_t res_next;
  step_result_t result;
  event_item_t  item;
  logic         s_accept;

  assign item     = event_item_t'(s_tdata[IN_BITS-1:0]);
  assign s_tready = ~m_tvalid | m_tready;
  assign s_accept = s_tvalid & s_tready;
  assign m_tdata  = {4'b0, result};

  i2cmts_step u_step (
    .cur                   (regs),
    .kind                  (s_tuser),
    .item                  (item),
    .ack_restore_enable    (ack_restore_enable),
    .subnode_events_enable (subnode_events_enable),
    .nxt                   (regs_next),
    .res                   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_restore_enable    <= 1'b1;
      subnode_events_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACK_RESTORE: ack_restore_enable    <= cfg_data;
        CFG_SUBNODE_EV:  subnode_events_enable <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs     <= '{xfer_state: ST_READY, default: '0};
      m_tvalid <= 1'b0;
    end else begin
      if (s_accept) begin
        regs     <= regs_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // hold the payload until the transaction completes
  always_ff @(posedge clk) begin
    if (s_accept) begin
      result <= res_next;
    end
  end

`ifndef SYNTH
  a_start_only_from_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.gen_start |-> result.prior_state == ST_READY)
    else $error("start requested while a transfer was busy");

  a_one_byte_direction: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(result.write_valid && result.read_valid))
    else $error("write and read byte in one result");

  a_done_returns_ready: assert property (@(posedge clk) disable iff (rst)
    s_accept && (res_next.notify == NT_TX_DONE || res_next.notify == NT_RX_DONE)
    |=> regs.xfer_state == ST_READY)
    else $error("transfer completion did not return to ready");

  a_count_never_grows: assert property (@(posedge clk) disable iff (rst)
    s_accept && s_tuser != KIND_SEND_REQ && s_tuser != KIND_RECV_REQ
    |=> regs.bytes_left <= $past(regs.bytes_left))
    else $error("byte count grew outside a request");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the I2C main transfer sequencer event stream.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmts_pkg::*;

  localparam logic       REG_ACK_RESTORE = 1'b0;
  localparam logic       REG_SUBNODE_EV  = 1'b1;
  localparam logic [3:0] KIND_TOP_CODE   = 4'hF;
  localparam logic [2:0] ERR_BUS         = 3'd0;
  localparam logic [2:0] ERR_ARB_LOST    = 3'd1;
  localparam logic [2:0] ERR_TIMEOUT     = 3'd4;
  localparam logic [2:0] ERR_CODE_TOP    = 3'd7;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PHASE_ITEMS    = 175;

  typedef struct {
    logic [3:0]   kind;
    event_item_t  ev;
    bit           pinned;
    step_result_t res;
  } plan_row_t;

  typedef struct {
    bit           pinned;
    step_result_t res;
  } pin_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_data = 1'b0;

  // predictor copy of the sequencer
  xfer_regs_t   regs = '0;
  logic         restore_ack = 1'b1;
  logic         subnode_force = 1'b0;

  step_result_t bus_action_q[$];
  pin_t         pin_q[$];
  plan_row_t    plan[$];

  int unsigned  fail_cnt = 0;
  int unsigned  items_sent = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  sink_stall_pct = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  hold_left = 0;
  bit           hold_trig = 1'b0;
  bit           hold_seen = 1'b0;

  i2c_master_transfer_sequencer_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic step_result_t predict_bus_action(logic [3:0] kind, event_item_t ev_in);
    step_result_t r;
    logic ev_en;
    logic er_en;
    r = '0;
    r.prior_state = regs.xfer_state;
    ev_en = regs.events_on | subnode_force;
    er_en = regs.errors_on | subnode_force;
    case (kind)
      KIND_SEND_REQ, KIND_RECV_REQ: begin
        if (regs.xfer_state == ST_READY) begin
          regs.bytes_left = ev_in.length;
          if (kind == KIND_RECV_REQ) begin
            regs.rx_total = ev_in.length;
            regs.xfer_state = ST_RX;
          end else begin
            regs.xfer_state = ST_TX;
          end
          regs.peer_addr = ev_in.target_addr;
          regs.keep_bus = ev_in.repeated_start;
          regs.events_on = 1'b1;
          regs.errors_on = 1'b1;
          r.gen_start = 1'b1;
        end
      end
      KIND_START: begin
        // address byte carries the read bit for a receive
        if (ev_en && (regs.xfer_state == ST_TX || regs.xfer_state == ST_RX)) begin
          r.write_valid = 1'b1;
          r.write_byte = {regs.peer_addr, regs.xfer_state == ST_RX};
        end
      end
      KIND_ADDR_DONE: begin
        if (ev_en && ev_in.main_mode && regs.xfer_state == ST_RX && regs.rx_total == 8'd1)
          r.ack_action = ACK_DISABLE;
      end
      KIND_TX_EMPTY: begin
        if (ev_en) begin
          if (ev_in.main_mode) begin
            if (regs.xfer_state == ST_TX && regs.bytes_left != 0) begin
              r.write_valid = 1'b1;
              r.write_byte = ev_in.tx_byte;
              regs.bytes_left = regs.bytes_left - 8'd1;
            end
          end else if (ev_in.transmitter) begin
            r.notify = NT_DATA_REQ;
          end
        end
      end
      KIND_RX_FULL: begin
        if (ev_en) begin
          if (ev_in.main_mode) begin
            if (regs.xfer_state == ST_RX) begin
              if (regs.rx_total != 0) begin
                if (regs.rx_total > 8'd1 && regs.bytes_left == 8'd2)
                  r.ack_action = ACK_DISABLE;
                r.read_valid = 1'b1;
                r.read_byte = ev_in.rx_byte;
                if (regs.bytes_left != 0)
                  regs.bytes_left = regs.bytes_left - 8'd1;
              end
              if (regs.bytes_left == 0) begin
                r.gen_stop = ~regs.keep_bus;
                regs.xfer_state = ST_READY;
                regs.events_on = 1'b0;
                regs.rx_total = '0;
                if (restore_ack)
                  r.ack_action = ACK_ENABLE;
                r.notify = NT_RX_DONE;
              end
            end
          end else if (!ev_in.transmitter) begin
            r.notify = NT_DATA_RCV;
          end
        end
      end
      KIND_BYTE_DONE: begin
        if (ev_en && regs.xfer_state == ST_TX && ev_in.tx_empty_flag && regs.bytes_left == 0)
        begin
          r.gen_stop = ~regs.keep_bus;
          regs.xfer_state = ST_READY;
          regs.events_on = 1'b0;
          r.notify = NT_TX_DONE;
        end
      end
      KIND_STOP: begin
        if (ev_en)
          r.notify = NT_STOP;
      end
      KIND_ERROR: begin
        if (er_en && ev_in.error_code <= ERR_CODE_MAX)
          r.notify = NT_ERR_BASE + {1'b0, ev_in.error_code};
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic event_item_t mk_ev(logic [7:0] length, logic [6:0] addr, logic rs,
                                       logic [7:0] txb, logic [7:0] rxb, logic main_m,
                                       logic tra, logic txe, logic [2:0] ecode);
    event_item_t ev;
    ev.length = length;
    ev.target_addr = addr;
    ev.repeated_start = rs;
    ev.tx_byte = txb;
    ev.rx_byte = rxb;
    ev.main_mode = main_m;
    ev.transmitter = tra;
    ev.tx_empty_flag = txe;
    ev.error_code = ecode;
    return ev;
  endfunction

  function automatic step_result_t act(xfer_state_t ps, logic wv, logic [7:0] wb,
                                       logic st, logic sp, logic [3:0] nt);
    step_result_t r;
    r = '0;
    r.prior_state = ps;
    r.write_valid = wv;
    r.write_byte = wb;
    r.gen_start = st;
    r.gen_stop = sp;
    r.notify = nt;
    return r;
  endfunction

  function automatic event_item_t rand_ev(bit force_main);
    event_item_t ev;
    ev.length = 8'($urandom_range(255));
    ev.target_addr = 7'($urandom_range(127));
    ev.repeated_start = 1'($urandom_range(1));
    ev.tx_byte = 8'($urandom_range(255));
    ev.rx_byte = 8'($urandom_range(255));
    ev.main_mode = force_main ? 1'b1 : 1'($urandom_range(1));
    ev.transmitter = 1'($urandom_range(1));
    ev.tx_empty_flag = 1'($urandom_range(1));
    ev.error_code = 3'($urandom_range(7));
    return ev;
  endfunction

  // Call at a rising edge; returns at the edge where the transaction is taken.
  task automatic offer(logic [3:0] kind, event_item_t ev, bit pinned, step_result_t res);
    pin_t p;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    p.pinned = pinned;
    p.res = res;
    pin_q.push_back(p);
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {{(40 - IN_BITS){1'b0}}, ev};
    items_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bus_action_q.size() != 0 || m_tvalid) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(logic ack_on, logic sub_on);
    cfg_we <= 1'b1;
    cfg_index <= REG_ACK_RESTORE;
    cfg_data <= ack_on;
    @(posedge clk);
    cfg_index <= REG_SUBNODE_EV;
    cfg_data <= sub_on;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly whole transfers with random content, the rest noise and broken runs.
  task automatic run_traffic(int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    int unsigned reps;
    bit rx_dir;
    event_item_t ev;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        offer(4'($urandom_range(15)), rand_ev(1'b0), 1'b0, '0);
      end else begin
        rx_dir = $urandom_range(1);
        len = ($urandom_range(24) == 0) ? $urandom_range(12, 40) : $urandom_range(4);
        ev = rand_ev(1'b1);
        ev.length = 8'(len);
        offer(rx_dir ? KIND_RECV_REQ : KIND_SEND_REQ, ev, 1'b0, '0);
        offer(KIND_START, rand_ev(1'b1), 1'b0, '0);
        offer(KIND_ADDR_DONE, rand_ev(1'b1), 1'b0, '0);
        reps = (len == 0 || $urandom_range(4) == 0) ? len + 1 : len;
        for (int i = 0; i < reps; i++) begin
          if ($urandom_range(15) == 0) begin
            ev = rand_ev(1'b1);
            ev.error_code = 3'($urandom_range(ERR_CODE_MAX));
            offer($urandom_range(1) ? KIND_ERROR : KIND_STOP, ev, 1'b0, '0);
          end
          offer(rx_dir ? KIND_RX_FULL : KIND_TX_EMPTY, rand_ev(1'b1), 1'b0, '0);
        end
        if (!rx_dir) begin
          ev = rand_ev(1'b1);
          ev.tx_empty_flag = ($urandom_range(7) != 0);
          offer(KIND_BYTE_DONE, ev, 1'b0, '0);
        end
      end
    end
  endtask

  always @(posedge clk) begin : sink
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : scoreboard
    step_result_t got;
    step_result_t want;
    pin_t p;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = step_result_t'(m_tdata[OUT_BITS-1:0]);
        if (bus_action_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("tb: unexpected transaction %h at %0t", m_tdata, $realtime);
          fail_cnt++;
        end else begin
          want = bus_action_q.pop_front();
          if (got !== want || m_tdata[31:OUT_BITS] !== '0) begin
            if (fail_cnt < 10)
              $display("tb: mismatch at %0t: want %p, got %p (raw %h)",
                       $realtime, want, got, m_tdata);
            fail_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = predict_bus_action(s_tuser, event_item_t'(s_tdata[IN_BITS-1:0]));
        if (pin_q.size() != 0) begin
          p = pin_q.pop_front();
          if (p.pinned)
            want = p.res;
        end
        bus_action_q.push_back(want);
      end
      if (cfg_we) begin
        if (cfg_index == REG_ACK_RESTORE)
          restore_ack = cfg_data;
        else
          subnode_force = cfg_data;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    // idle events, then a send of length zero with busy, counter-floor and error checks
    plan.push_back('{KIND_STOP, mk_ev(0, 0, 0, 0, 0, 0, 0, 0, ERR_BUS), 1'b1,
                     act(ST_READY, 0, 8'h00, 0, 0, NT_NONE)});
    plan.push_back('{KIND_ERROR, mk_ev(0, 0, 0, 0, 0, 1, 0, 0, ERR_BUS), 1'b1,
                     act(ST_READY, 0, 8'h00, 0, 0, NT_NONE)});
    plan.push_back('{KIND_SEND_REQ, mk_ev(0, 7'h7F, 0, 0, 0, 1, 1, 0, ERR_BUS), 1'b1,
                     act(ST_READY, 0, 8'h00, 1, 0, NT_NONE)});
    plan.push_back('{KIND_SEND_REQ, mk_ev(8'hFF, 7'h11, 1, 0, 0, 1, 1, 0, ERR_BUS), 1'b1,
                     act(ST_TX, 0, 8'h00, 0, 0, NT_NONE)});
    plan.push_back('{KIND_START, mk_ev(0, 0, 0, 0, 0, 1, 1, 0, ERR_BUS), 1'b1,
                     act(ST_TX, 1, 8'hFE, 0, 0, NT_NONE)});
    plan.push_back('{KIND_TX_EMPTY, mk_ev(0, 0, 0, 8'hAA, 0, 1, 1, 1, ERR_BUS), 1'b1,
                     act(ST_TX, 0, 8'h00, 0, 0, NT_NONE)});
    plan.push_back('{KIND_ERROR, mk_ev(0, 0, 0, 0, 0, 1, 1, 0, ERR_TIMEOUT), 1'b1,
                     act(ST_TX, 0, 8'h00, 0, 0, NT_ERR_BASE + ERR_TIMEOUT)});
    plan.push_back('{KIND_ERROR, mk_ev(0, 0, 0, 0, 0, 1, 1, 0, ERR_CODE_TOP), 1'b1,
                     act(ST_TX, 0, 8'h00, 0, 0, NT_NONE)});
    plan.push_back('{KIND_BYTE_DONE, mk_ev(0, 0, 0, 0, 0, 1, 1, 1, ERR_BUS), 1'b1,
                     act(ST_TX, 0, 8'h00, 0, 1, NT_TX_DONE)});
    plan.push_back('{KIND_ERROR, mk_ev(0, 0, 0, 0, 0, 1, 1, 0, ERR_ARB_LOST), 1'b1,
                     act(ST_READY, 0, 8'h00, 0, 0, NT_ERR_BASE + ERR_ARB_LOST)});
    plan.push_back('{KIND_TOP_CODE, mk_ev(8'hFF, 7'h7F, 1, 8'hFF, 8'hFF, 1, 1, 1, ERR_CODE_TOP),
                     1'b1, act(ST_READY, 0, 8'h00, 0, 0, NT_NONE)});
    // one-byte receive with repeated start, zero-length receive, three-byte receive
    plan.push_back('{KIND_RECV_REQ, mk_ev(1, 7'h00, 1, 0, 0, 1, 0, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_START, mk_ev(0, 0, 0, 0, 0, 1, 0, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_ADDR_DONE, mk_ev(0, 0, 0, 0, 0, 1, 0, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_RX_FULL, mk_ev(0, 0, 0, 0, 8'hFF, 1, 0, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_RECV_REQ, mk_ev(0, 7'h55, 0, 0, 0, 1, 0, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_RX_FULL, mk_ev(0, 0, 0, 0, 8'h3C, 1, 0, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_RECV_REQ, mk_ev(3, 7'h2A, 0, 0, 0, 1, 0, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_RX_FULL, mk_ev(0, 0, 0, 0, 8'h00, 1, 0, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_RX_FULL, mk_ev(0, 0, 0, 0, 8'hA5, 1, 0, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_RX_FULL, mk_ev(0, 0, 0, 0, 8'h5A, 1, 0, 0, ERR_BUS), 1'b0, '0});
    // subnode notifications inside a send, which then ends with the bus kept
    plan.push_back('{KIND_SEND_REQ, mk_ev(8'h01, 7'h01, 1, 0, 0, 1, 1, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_TX_EMPTY, mk_ev(0, 0, 0, 8'h12, 0, 0, 1, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_RX_FULL, mk_ev(0, 0, 0, 0, 8'h34, 0, 0, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_TX_EMPTY, mk_ev(0, 0, 0, 8'hFF, 0, 1, 1, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_STOP, mk_ev(0, 0, 0, 0, 0, 1, 1, 0, ERR_BUS), 1'b0, '0});
    plan.push_back('{KIND_BYTE_DONE, mk_ev(0, 0, 0, 0, 0, 1, 1, 1, ERR_BUS), 1'b0, '0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i])
      offer(plan[i].kind, plan[i].ev, plan[i].pinned, plan[i].res);

    drain();
    load_config(1'b1, 1'b0);
    run_traffic(PHASE_ITEMS);

    drain();
    load_config(1'b0, 1'b0);
    src_idle_pct = 71;
    run_traffic(PHASE_ITEMS);

    drain();
    load_config(1'b1, 1'b1);
    src_idle_pct = 0;
    sink_stall_pct <= 71;
    run_traffic(PHASE_ITEMS);

    drain();
    load_config(1'b0, 1'b1);
    src_idle_pct = 33;
    sink_stall_pct <= 33;
    run_traffic(PHASE_ITEMS);

    // hold the output off while the source keeps pushing
    drain();
    load_config(1'b1, 1'b0);
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    hold_trig <= ~hold_trig;
    run_traffic(PHASE_ITEMS);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bus_action_q.size() != 0 || m_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_cnt == 0 && bus_action_q.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/i2cmts_pkg.sv
rtl/core/i2cmts_step.sv
rtl/core/i2c_master_transfer_sequencer_top.sv
tb/tb.sv
